/* rtl/core/cis_pkg.sv */
// Shared types and constants for the compacting identifier set.
package cis_pkg;

    // Fixed field widths of the channels.
    localparam int unsigned ID_W     = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned ACTION_W = 2;

    // The identifier value that marks an empty entry.
    localparam logic [ID_W-1:0] EMPTY_ID = '1;

    // Action codes carried on the input channel.
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

    // Strobes that the controller broadcasts to every cell of the row.
    typedef struct packed {
        logic cmp_en;   // latch the compare and read select results
        logic add_en;   // the first free cell takes the request id
        logic del_en;   // cells at or after the hit take their right neighbor
    } cis_ctl_t;

endpackage

/* rtl/core/compacting_id_set_top.sv */
// Top level of the compacting identifier set: controller, cell row and result register.
//
//  Channel | Ports                                       | Direction | Handshake
//  input   | s_action, s_id, s_position                  | in        | s_valid / s_ready
//  result  | m_status, m_found, m_read_id, m_count,      | out       | m_valid / m_ready
//          | m_full_res, m_empty_res                     |           |
//
// Each beat passes through capture, compare in every cell, then update.
// The steps follow from the registered compare in the cell row and the update
// that follows it; one beat is in work at a time.
// The update waits while the result register still holds an untaken beat.
// Synchronous active-low reset empties the set; no clearing pass is needed.
module compacting_id_set_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cis_pkg::ACTION_W-1:0] s_action,
    input  logic signed [cis_pkg::ID_W-1:0] s_id,
    input  logic [cis_pkg::POS_W-1:0]    s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic                         m_found,
    output logic signed [cis_pkg::ID_W-1:0] m_read_id,
    output logic [cis_pkg::COUNT_W-1:0]  m_count,
    output logic                         m_full_res,
    output logic                         m_empty_res
);
    import cis_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

    state_t              state_reg;
    logic [ACTION_W-1:0] req_action_reg;
    logic [ID_W-1:0]     req_id_reg;
    logic [POS_W-1:0]    req_pos_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                m_valid_reg;
    logic                m_status_reg, m_status_next;
    logic                m_found_reg, m_found_next;
    logic [ID_W-1:0]     m_read_id_reg, m_read_id_next;
    logic [CNT_W-1:0]    m_count_reg;

    cis_ctl_t            ctl;
    logic                out_free;
    logic                upd_go;
    logic                any_match, any_sel;
    logic                id_is_empty, is_full;
    logic                add_ok, del_ok;
    logic [ID_W-1:0]     rd_or;

    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY-1:0] cell_sel;
    logic [CAPACITY:0]   seen;
    logic [ID_W-1:0]     cell_entry [CAPACITY];
    logic [ID_W-1:0]     cell_rd    [CAPACITY];

    // Row of cells; each one looks at its left neighbor's valid bit for adds
    // and takes its right neighbor's entry when a delete closes a gap.
    assign seen[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            prev_v;
        logic            next_v;
        logic [ID_W-1:0] next_e;
        if (g == 0) begin : g_first
            assign prev_v = 1'b1;
        end else begin : g_rest
            assign prev_v = cell_valid[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_v = 1'b0;
            assign next_e = EMPTY_ID;
        end else begin : g_inner
            assign next_v = cell_valid[g+1];
            assign next_e = cell_entry[g+1];
        end
        cis_cell #(.IDX(g)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .req_id     (req_id_reg),
            .req_pos    (req_pos_reg),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_entry (next_e),
            .seen_in    (seen[g]),
            .seen_out   (seen[g+1]),
            .valid      (cell_valid[g]),
            .entry      (cell_entry[g]),
            .match      (cell_match[g]),
            .sel        (cell_sel[g]),
            .rd_data    (cell_rd[g])
        );
    end

    // Gather the row's compare and read results.
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end
    assign any_match = |cell_match;
    assign any_sel   = |cell_sel;

    // Decide the action.
    assign id_is_empty = (req_id_reg == EMPTY_ID);
    assign is_full     = (cnt_reg == CNT_W'(CAPACITY));
    assign add_ok      = (req_action_reg == ACT_ADD) && !id_is_empty && !any_match && !is_full;
    assign del_ok      = (req_action_reg == ACT_DEL) && !id_is_empty && any_match;

    assign out_free   = !m_valid_reg || m_ready;
    assign upd_go     = (state_reg == S_UPD) && out_free;
    assign ctl.cmp_en = (state_reg == S_CMP);
    assign ctl.add_en = upd_go && add_ok;
    assign ctl.del_en = upd_go && del_ok;
    assign s_ready    = (state_reg == S_IDLE);

    // Result fields for the beat in the update cycle.
    always_comb begin
        cnt_next       = cnt_reg;
        m_status_next  = 1'b0;
        m_found_next   = 1'b0;
        m_read_id_next = EMPTY_ID;
        unique case (req_action_reg)
            ACT_ADD: begin
                m_status_next = !add_ok;
                if (add_ok) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ACT_DEL: begin
                m_status_next = !del_ok;
                if (del_ok) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ACT_QUERY: begin
                m_found_next = !id_is_empty && any_match;
            end
            ACT_READ: begin
                if (any_sel) begin
                    m_read_id_next = rd_or;
                end
            end
            default: begin
                m_status_next = 1'b0;
            end
        endcase
    end

    // Controller and result register; a new result beat takes priority over
    // the clear of a beat that leaves in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (upd_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                        cnt_reg   <= cnt_next;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_action_reg <= s_action;
            req_id_reg     <= s_id;
            req_pos_reg    <= s_position;
        end
        if (upd_go) begin
            m_status_reg  <= m_status_next;
            m_found_reg   <= m_found_next;
            m_read_id_reg <= m_read_id_next;
            m_count_reg   <= cnt_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_found     = m_found_reg;
    assign m_read_id   = m_read_id_reg;
    assign m_count     = COUNT_W'(m_count_reg);
    assign m_full_res  = (m_count_reg == CNT_W'(CAPACITY));
    assign m_empty_res = (m_count_reg == '0);

endmodule

/* rtl/core/cis_cell.sv */
// One entry cell of the set: holds an id, compares it and shifts on delete.
module cis_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cis_pkg::cis_ctl_t        ctl,
    input  logic [cis_pkg::ID_W-1:0] req_id,
    input  logic [cis_pkg::POS_W-1:0] req_pos,
    input  logic                     prev_valid,
    input  logic                     next_valid,
    input  logic [cis_pkg::ID_W-1:0] next_entry,
    input  logic                     seen_in,
    output logic                     seen_out,
    output logic                     valid,
    output logic [cis_pkg::ID_W-1:0] entry,
    output logic                     match,
    output logic                     sel,
    output logic [cis_pkg::ID_W-1:0] rd_data
);
    import cis_pkg::*;

    logic            valid_reg, valid_next;
    logic [ID_W-1:0] entry_reg, entry_next;
    logic            match_reg;
    logic            sel_reg;
    logic            shift_en;

    // A delete hit somewhere at or to the left of this cell moves the right
    // neighbor in.
    assign seen_out = seen_in | match_reg;
    assign shift_en = ctl.del_en & seen_out;

    // Next entry state.
    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (shift_en) begin
            valid_next = next_valid;
            entry_next = next_entry;
        end else if (ctl.add_en && prev_valid && !valid_reg) begin
            valid_next = 1'b1;
            entry_next = req_id;
        end
    end

    // Control state of the cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.cmp_en) begin
                match_reg <= valid_reg && (entry_reg == req_id);
                sel_reg   <= valid_reg && (req_pos == POS_W'(IDX));
            end
        end
    end

    // Stored identifier.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign valid   = valid_reg;
    assign entry   = entry_reg;
    assign match   = match_reg;
    assign sel     = sel_reg;
    assign rd_data = sel_reg ? entry_reg : '0;

endmodule

/* rtl/core/cis_checker.sv */
// Port-level checks for the compacting identifier set, bound to the top level.
module cis_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_status,
    input logic                         m_found,
    input logic [cis_pkg::ID_W-1:0]     m_read_id,
    input logic [cis_pkg::COUNT_W-1:0]  m_count,
    input logic                         m_full_res,
    input logic                         m_empty_res
);
    import cis_pkg::*;

    // A stalled result beat holds its read data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_id))
        else $error("result beat changed while stalled");

    // The count never passes the store size.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    // The full flag agrees with the count.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_full_res == (m_count == COUNT_W'(CAPACITY)))
        else $error("full flag disagrees with count");

    // The empty flag agrees with the count.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_empty_res == (m_count == '0))
        else $error("empty flag disagrees with count");

    // A hit only comes from a query, which reports ok and no read data.
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_status && (m_read_id == EMPTY_ID))
        else $error("found set on a beat that is not a clean query");

endmodule

bind compacting_id_set_top cis_checker #(.CAPACITY(CAPACITY)) u_cis_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_found     (m_found),
    .m_read_id   (m_read_id),
    .m_count     (m_count),
    .m_full_res  (m_full_res),
    .m_empty_res (m_empty_res)
);
